// ===== sv/aes_pkg.sv =====
package aes_pkg;

    // key store size in 32-bit words
    localparam int KEY_STORE_WORDS = 60;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BITS_0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BITS_3 = 3'd4;

    // key length codes
    localparam logic [1:0] KLEN_192 = 2'd1;
    localparam logic [1:0] KLEN_256 = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FETCH,
        ST_ROUND,
        ST_WRITE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic blk_load;
        logic exp_step;
        logic rd_step;
        logic round_step;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic exp_last;
        logic round_last;
        logic cfg_hit;
    } dp_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // inverse table, built at elaboration from the forward table
    function automatic logic [255:0][7:0] build_inv();
        logic [255:0][7:0] t;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam logic [255:0][7:0] INV_SBOX = build_inv();

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        return p;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte b of the state sits at bits 127-8b downto 120-8b; byte 4c+r is row r, column c
    function automatic logic [127:0] sbox_state(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int b = 0; b < 16; b++) begin
            t[127-8*b -: 8] = inv ? INV_SBOX[s[127-8*b -: 8]] : SBOX[s[127-8*b -: 8]];
        end
        return t;
    endfunction

    function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
                t[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0] c0, c1, c2, c3;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                c0 = s[127-8*(4*c+r) -: 8];
                c1 = s[127-8*(4*c+((r+1)&3)) -: 8];
                c2 = s[127-8*(4*c+((r+2)&3)) -: 8];
                c3 = s[127-8*(4*c+((r+3)&3)) -: 8];
                if (inv) begin
                    t[127-8*(4*c+r) -: 8] = gf_mul(8'h0e, c0) ^ gf_mul(8'h0b, c1) ^
                                            gf_mul(8'h0d, c2) ^ gf_mul(8'h09, c3);
                end else begin
                    t[127-8*(4*c+r) -: 8] = gf_mul(8'h02, c0) ^ gf_mul(8'h03, c1) ^ c2 ^ c3;
                end
            end
        end
        return t;
    endfunction

endpackage

// ===== sv/aes_ram.sv =====
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/aes_ctrl.sv =====
module aes_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  aes_pkg::dp_status_t status,
    output aes_pkg::ctrl_cmd_t  cmd
);

    aes_pkg::state_t state_reg, state_next;
    logic keys_ready_reg, keys_ready_next;
    logic out_valid_reg, out_valid_next;

    // state and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= aes_pkg::ST_IDLE;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            keys_ready_reg <= keys_ready_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        keys_ready_next = keys_ready_reg;
        out_valid_next  = out_valid_reg;
        cmd             = '0;
        in_ready        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (status.cfg_hit)
        begin
            keys_ready_next = 1'b0;
        end

        unique case (state_reg)
            aes_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.blk_load = 1'b1;
                    state_next   = keys_ready_reg ? aes_pkg::ST_FETCH : aes_pkg::ST_EXPAND;
                end
            end
            aes_pkg::ST_EXPAND:
            begin
                cmd.exp_step = 1'b1;
                if (status.exp_last)
                begin
                    keys_ready_next = 1'b1;
                    state_next      = aes_pkg::ST_FETCH;
                end
            end
            aes_pkg::ST_FETCH:
            begin
                cmd.rd_step = 1'b1;
                state_next  = aes_pkg::ST_ROUND;
            end
            aes_pkg::ST_ROUND:
            begin
                cmd.rd_step    = 1'b1;
                cmd.round_step = 1'b1;
                if (status.round_last)
                begin
                    state_next = aes_pkg::ST_WRITE;
                end
            end
            aes_pkg::ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = aes_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aes_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/aes_dp.sv =====
module aes_dp #(
    parameter int KEY_STORE_WORDS = aes_pkg::KEY_STORE_WORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic                            action,
    input  logic [63:0]                     block_high,
    input  logic [63:0]                     block_low,
    output logic [63:0]                     result_high,
    output logic [63:0]                     result_low,
    input  aes_pkg::ctrl_cmd_t              cmd,
    output aes_pkg::dp_status_t             status
);

    localparam int ROWS = KEY_STORE_WORDS / 4;
    localparam int RAW  = $clog2(ROWS);
    localparam int RDW  = $clog2(ROWS + 1);
    localparam int WCW  = $clog2(KEY_STORE_WORDS + 1);
    localparam bit FIT_192 = (52 <= KEY_STORE_WORDS);
    localparam bit FIT_256 = (60 <= KEY_STORE_WORDS);

    logic [1:0]       key_len_reg;
    logic [63:0]      key_reg [4];
    logic [WCW-1:0]   wcnt_reg;
    logic [2:0]       mod_reg;
    logic [7:0]       rcon_reg;
    logic [31:0]      win_reg [8];
    logic [95:0]      rowbuf_reg;
    logic [RDW-1:0]   rd_reg;
    logic             dec_reg;
    logic [127:0]     state_reg, state_next;
    logic [127:0]     result_reg;

    logic [3:0]       nk, nr;
    logic [WCW-1:0]   nk_w, total_w;
    logic [RDW-1:0]   nr_r, row_sel;
    logic [WCW-1:0]   wrow;
    logic [31:0]      key_word, prev, back, tmp, word;
    logic             ram_we;
    logic [RAW-1:0]   ram_waddr, ram_raddr;
    logic [127:0]     ram_wdata, round_key;
    logic             first_step, last_step;

    // key size from the length register, falling back to 128 bits
    always_comb
    begin
        nk = 4'd4;
        if (key_len_reg == aes_pkg::KLEN_192 && FIT_192)
        begin
            nk = 4'd6;
        end
        else if (key_len_reg == aes_pkg::KLEN_256 && FIT_256)
        begin
            nk = 4'd8;
        end
        nr      = nk + 4'd6;
        nk_w    = WCW'(nk);
        total_w = WCW'({nr + 4'd1, 2'b00});
        nr_r    = RDW'(nr);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == aes_pkg::REG_KEY_LENGTH)
            begin
                key_len_reg <= cfg_data[1:0];
            end
            else if (cfg_index <= aes_pkg::REG_KEY_BITS_3)
            begin
                key_reg[2'(cfg_index - aes_pkg::REG_KEY_BITS_0)] <= cfg_data;
            end
        end
    end

    assign status.cfg_hit = cfg_valid && (cfg_index <= aes_pkg::REG_KEY_BITS_3);

    // key schedule word, one per cycle
    always_comb
    begin
        key_word = wcnt_reg[0] ? key_reg[wcnt_reg[2:1]][31:0] : key_reg[wcnt_reg[2:1]][63:32];
        prev     = win_reg[0];
        back     = win_reg[3'(nk - 4'd1)];
        if (mod_reg == 3'd0)
        begin
            tmp = aes_pkg::sbox_word({prev[23:0], prev[31:24]}) ^ {rcon_reg, 24'h0};
        end
        else if (nk == 4'd8 && mod_reg == 3'd4)
        begin
            tmp = aes_pkg::sbox_word(prev);
        end
        else
        begin
            tmp = prev;
        end
        word = (wcnt_reg < nk_w) ? key_word : (back ^ tmp);
    end

    assign status.exp_last = (wcnt_reg == total_w - WCW'(1));

    // expansion counters and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else if (cmd.blk_load)
        begin
            wcnt_reg <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else if (cmd.exp_step)
        begin
            wcnt_reg <= wcnt_reg + WCW'(1);
            mod_reg  <= (mod_reg == 3'(nk - 4'd1)) ? 3'd0 : mod_reg + 3'd1;
            if (wcnt_reg >= nk_w && mod_reg == 3'd0)
            begin
                rcon_reg <= aes_pkg::xtime(rcon_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exp_step)
        begin
            win_reg[0] <= word;
            for (int i = 1; i < 8; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
            rowbuf_reg <= {rowbuf_reg[63:0], word};
        end
    end

    // one row of four words is written at every fourth word
    assign wrow      = wcnt_reg >> 2;
    assign ram_we    = cmd.exp_step && (wcnt_reg[1:0] == 2'b11);
    assign ram_waddr = wrow[RAW-1:0];
    assign ram_wdata = {rowbuf_reg, word};

    // round key row, forward for encryption and backward for decryption
    assign row_sel   = dec_reg ? (nr_r - rd_reg) : rd_reg;
    assign ram_raddr = row_sel[RAW-1:0];

    aes_ram #(
        .WIDTH (128),
        .DEPTH (ROWS)
    ) u_key_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (round_key)
    );

    assign first_step        = (rd_reg == RDW'(1));
    assign last_step         = (rd_reg == nr_r + RDW'(1));
    assign status.round_last = last_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
        end
        else if (cmd.blk_load)
        begin
            rd_reg <= '0;
        end
        else if (cmd.rd_step)
        begin
            rd_reg <= rd_reg + RDW'(1);
        end
    end

    // shared round unit
    always_comb
    begin
        state_next = state_reg;
        if (first_step)
        begin
            state_next = state_reg ^ round_key;
        end
        else if (!dec_reg)
        begin
            state_next = aes_pkg::rotate_rows(aes_pkg::sbox_state(state_reg, 1'b0), 1'b0);
            if (!last_step)
            begin
                state_next = aes_pkg::mix_state(state_next, 1'b0);
            end
            state_next = state_next ^ round_key;
        end
        else
        begin
            state_next = aes_pkg::sbox_state(aes_pkg::rotate_rows(state_reg, 1'b1), 1'b1)
                         ^ round_key;
            if (!last_step)
            begin
                state_next = aes_pkg::mix_state(state_next, 1'b1);
            end
        end
    end

    // block state and result
    always_ff @(posedge clk)
    begin
        if (cmd.blk_load)
        begin
            state_reg <= {block_high, block_low};
            dec_reg   <= action;
        end
        else if (cmd.round_step)
        begin
            state_reg <= state_next;
        end
        if (cmd.out_load)
        begin
            result_reg <= state_reg;
        end
    end

    assign result_high = result_reg[127:64];
    assign result_low  = result_reg[63:0];

endmodule

// ===== sv/aes_block_cipher_unit.sv =====
// AES block engine for 128, 192 and 256-bit keys (key_length 0, 1, 2; code 3 means 128).
// One 128-bit block per transaction, encrypted when action is 0 and decrypted when it is 1.
// The first block after any key register write first expands the key into the round key
// store, one word per cycle, 44, 52 or 60 words in all. After that the single round unit
// does one round per cycle, with its round key from the registered key store read port.
// One block is in work at a time; a finished result waits in an output register, and the
// next block is accepted while it waits. Configuration writes are taken at any cycle and
// must be made only while the engine is idle.
module aes_block_cipher_unit #(
    parameter int KEY_STORE_WORDS = aes_pkg::KEY_STORE_WORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [63:0]                     block_high,
    input  logic [63:0]                     block_low,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [63:0]                     result_high,
    output logic [63:0]                     result_low
);

    aes_pkg::ctrl_cmd_t  cmd;
    aes_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    aes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // key schedule, key store and round unit
    aes_dp #(
        .KEY_STORE_WORDS (KEY_STORE_WORDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .action      (action),
        .block_high  (block_high),
        .block_low   (block_low),
        .result_high (result_high),
        .result_low  (result_low),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== sv/aes_checker.sv =====
module aes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result_high,
    input logic [63:0] result_low
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_high) && $stable(result_low))
        else $error("stalled result changed");

    // one block in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken right after a transaction");

    // no block finishes before it reaches the round state
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 !in_ready)
        else $error("block finished too early");

endmodule

bind aes_block_cipher_unit aes_checker u_aes_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_high (result_high),
    .result_low  (result_low)
);
